[src/rsmt_pkg.sv]
// ----------------------------------------------------------------------------
// rsmt_pkg: shared types and constants of the radix sort core
// Key type codes, register indexes, controller states, the command and status
// bundles between controller and datapath, and the key order mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package rsmt_pkg;

    // Key type codes held in the key_type register.
    localparam logic [2:0] KT_U32    = 3'd0;
    localparam logic [2:0] KT_S32    = 3'd1;
    localparam logic [2:0] KT_DOUBLE = 3'd2;
    localparam logic [2:0] KT_FLOAT  = 3'd3;
    localparam logic [2:0] KT_S64    = 3'd4;
    localparam logic [2:0] KT_U64    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KEY_TYPE   = 2'd0;
    localparam logic [1:0] CFG_DESCENDING = 2'd1;

    // Command codes on the func input.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HIST_ORD,
        ST_HIST_KEY,
        ST_HIST_CNT,
        ST_HIST_UPD,
        ST_PREFIX,
        ST_SCAT_ORD,
        ST_SCAT_KEY,
        ST_SCAT_CNT,
        ST_SCAT_UPD,
        ST_RD_ORD,
        ST_RD_KEY,
        ST_RD_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sort_init;
        logic clear_step;
        logic item_key;
        logic item_cnt;
        logic hist_upd;
        logic scat_upd;
        logic pfx_step;
        logic pass_adv;
        logic sort_done;
        logic read_mode;
        logic rd_emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_end;
        logic pfx_end;
        logic item_last;
        logic pass_last;
    } dp_sts_t;

    // True for the key types that sort on 32 bits.
    function automatic logic is_narrow(input logic [2:0] kt);
        return (kt == KT_U32) || (kt == KT_S32) || (kt == KT_FLOAT);
    endfunction

    // Map raw key bits to an unsigned order.
    function automatic logic [63:0] order_key(input logic [63:0] raw, input logic [2:0] kt);
        logic [31:0] lo;
        logic [63:0] res;
        lo = raw[31:0];
        case (kt)
            KT_U32:    res = {32'd0, lo};
            KT_S32:    res = {32'd0, lo ^ SIGN32};
            KT_FLOAT:  res = {32'd0, (lo[31] ? ~lo : (lo ^ SIGN32))};
            KT_DOUBLE: res = raw[63] ? ~raw : (raw ^ SIGN64);
            KT_S64:    res = raw ^ SIGN64;
            default:   res = raw;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[src/rsmt_ctrl.sv]
// ----------------------------------------------------------------------------
// rsmt_ctrl: sequencer of the radix sort core
// Walks loads, read-outs and the clear, histogram, prefix and scatter phases
// of each sort pass, and drives the datapath by command signals.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              func,
    input  wire logic              last,
    input  wire rsmt_pkg::dp_sts_t sts,
    output logic                   busy,
    output rsmt_pkg::dp_cmd_t      cmd
);
    import rsmt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        if (last)
                        begin
                            state_next = ST_CLEAR;
                        end
                    end
                    else
                    begin
                        state_next = ST_RD_ORD;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (sts.clr_end)
                begin
                    state_next = ST_HIST_ORD;
                end
            end
            ST_HIST_ORD: state_next = ST_HIST_KEY;
            ST_HIST_KEY: state_next = ST_HIST_CNT;
            ST_HIST_CNT: state_next = ST_HIST_UPD;
            ST_HIST_UPD:
            begin
                state_next = sts.item_last ? ST_PREFIX : ST_HIST_ORD;
            end
            ST_PREFIX:
            begin
                if (sts.pfx_end)
                begin
                    state_next = ST_SCAT_ORD;
                end
            end
            ST_SCAT_ORD: state_next = ST_SCAT_KEY;
            ST_SCAT_KEY: state_next = ST_SCAT_CNT;
            ST_SCAT_CNT: state_next = ST_SCAT_UPD;
            ST_SCAT_UPD:
            begin
                if (sts.item_last)
                begin
                    state_next = sts.pass_last ? ST_IDLE : ST_CLEAR;
                end
                else
                begin
                    state_next = ST_SCAT_ORD;
                end
            end
            ST_RD_ORD: state_next = ST_RD_KEY;
            ST_RD_KEY: state_next = ST_RD_OUT;
            ST_RD_OUT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd            = '0;
        busy           = (state_reg != ST_IDLE);
        cmd.load       = accept && (func == FUNC_LOAD);
        cmd.sort_init  = accept && (func == FUNC_LOAD) && last;
        case (state_reg)
            ST_CLEAR:    cmd.clear_step = 1'b1;
            ST_HIST_KEY: cmd.item_key   = 1'b1;
            ST_HIST_CNT: cmd.item_cnt   = 1'b1;
            ST_HIST_UPD: cmd.hist_upd   = 1'b1;
            ST_PREFIX:   cmd.pfx_step   = 1'b1;
            ST_SCAT_KEY: cmd.item_key   = 1'b1;
            ST_SCAT_CNT: cmd.item_cnt   = 1'b1;
            ST_SCAT_UPD:
            begin
                cmd.scat_upd  = 1'b1;
                cmd.pass_adv  = sts.item_last && !sts.pass_last;
                cmd.sort_done = sts.item_last && sts.pass_last;
            end
            ST_RD_ORD:   cmd.read_mode  = 1'b1;
            ST_RD_KEY:   cmd.read_mode  = 1'b1;
            ST_RD_OUT:
            begin
                cmd.read_mode = 1'b1;
                cmd.rd_emit   = 1'b1;
            end
            default:     cmd.read_mode  = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[src/rsmt_datapath.sv]
// ----------------------------------------------------------------------------
// rsmt_datapath: storage and arithmetic of the radix sort core
// Holds key and tag stores, the ping and pong order buffers, the digit count
// memory, the set counters, configuration and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rsmt_datapath #(
    parameter int MAX_ITEMS  = 4096,
    parameter int DIGIT_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rsmt_pkg::dp_cmd_t cmd,
    output rsmt_pkg::dp_sts_t      sts,
    input  wire logic [63:0]       key,
    input  wire logic [30:0]       tag,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [2:0]        cfg_data,
    output logic                   res_valid,
    output logic [63:0]            sorted_key,
    output logic [30:0]            sorted_tag,
    output logic                   final_res,
    output logic                   status,
    output logic                   overflowed
);
    import rsmt_pkg::*;

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int NB  = 2 ** DIGIT_BITS;
    localparam int BW  = DIGIT_BITS + 1;
    localparam int P32 = (32 + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int P64 = (64 + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PW  = $clog2(P64);
    localparam int SW  = 7;

    // Memories.
    logic [63:0]         key_mem  [MAX_ITEMS];
    logic [30:0]         tag_mem  [MAX_ITEMS];
    logic [AW-1:0]       ping_mem [MAX_ITEMS];
    logic [AW-1:0]       pong_mem [MAX_ITEMS];
    logic [CW-1:0]       cnt_mem  [NB];

    // Control registers.
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rp_reg, rp_next;
    logic                ready_reg, ready_next;
    logic                ovf_reg, ovf_next;
    logic [2:0]          kt_reg, kt_next;
    logic                desc_reg, desc_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [PW-1:0]       pass_reg, pass_next;
    logic [CW-1:0]       run_reg, run_next;
    logic                fsel_reg, fsel_next;
    logic                res_valid_reg, res_valid_next;

    // Payload registers.
    logic [63:0]         key_rdata;
    logic [30:0]         tag_rdata;
    logic [AW-1:0]       ping_rdata;
    logic [AW-1:0]       pong_rdata;
    logic [CW-1:0]       cnt_rdata;
    logic [AW-1:0]       it_reg;
    logic [DIGIT_BITS-1:0] digit_reg;
    logic [63:0]         out_key_reg;
    logic [30:0]         out_tag_reg;
    logic                out_final_reg;
    logic                out_status_reg;
    logic                out_ovf_reg;

    // Combinational signals.
    logic                store_ok;
    logic [AW-1:0]       store_addr;
    logic [AW-1:0]       ord_raddr;
    logic [AW-1:0]       src_data;
    logic [AW-1:0]       final_data;
    logic [AW-1:0]       key_raddr;
    logic [SW-1:0]       shift;
    logic [63:0]         okey;
    logic [63:0]         shifted;
    logic [DIGIT_BITS-1:0] digit;
    logic [DIGIT_BITS-1:0] cnt_raddr;
    logic                cnt_we;
    logic [DIGIT_BITS-1:0] cnt_waddr;
    logic [CW-1:0]       cnt_wdata;
    logic [CW-1:0]       cnt_inc;
    logic [BW-1:0]       b_prev;
    logic [PW-1:0]       last_pass;
    logic                rd_ok;
    logic                is_first_pass;

    // Load slot: a load after a finished sort opens a new set at slot zero.
    assign store_ok   = ready_reg || (count_reg < CW'(MAX_ITEMS));
    assign store_addr = ready_reg ? '0 : count_reg[AW-1:0];

    // Order buffer addressing. Pass zero reads the load order directly.
    assign is_first_pass = (pass_reg == '0);
    assign ord_raddr  = cmd.read_mode ? rp_reg[AW-1:0] : i_reg;
    assign src_data   = pass_reg[0] ? pong_rdata : ping_rdata;
    assign final_data = fsel_reg ? ping_rdata : pong_rdata;
    assign key_raddr  = cmd.read_mode ? final_data : (is_first_pass ? i_reg : src_data);

    // Digit extraction of the current pass.
    assign shift   = SW'(pass_reg) * SW'(DIGIT_BITS);
    assign okey    = order_key(key_rdata, kt_reg);
    assign shifted = okey >> shift;
    assign digit   = desc_reg ? ~shifted[DIGIT_BITS-1:0] : shifted[DIGIT_BITS-1:0];

    // Count memory ports.
    assign cnt_inc   = cnt_rdata + CW'(1);
    assign b_prev    = b_reg - BW'(1);
    assign cnt_raddr = cmd.pfx_step ? b_reg[DIGIT_BITS-1:0] : digit;
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = digit_reg;
        cnt_wdata = cnt_inc;
        if (cmd.clear_step)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = b_reg[DIGIT_BITS-1:0];
            cnt_wdata = '0;
        end
        else if (cmd.pfx_step)
        begin
            cnt_we    = (b_reg != '0);
            cnt_waddr = b_prev[DIGIT_BITS-1:0];
            cnt_wdata = run_reg;
        end
        else if (cmd.hist_upd || cmd.scat_upd)
        begin
            cnt_we = 1'b1;
        end
    end

    // Status to the controller.
    assign last_pass     = is_narrow(kt_reg) ? PW'(P32 - 1) : PW'(P64 - 1);
    assign sts.clr_end   = (b_reg == BW'(NB - 1));
    assign sts.pfx_end   = (b_reg == BW'(NB));
    assign sts.item_last = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign sts.pass_last = (pass_reg == last_pass);

    assign rd_ok = ready_reg && (rp_reg < count_reg);

    // Next values of the control registers.
    always_comb
    begin
        count_next     = count_reg;
        rp_next        = rp_reg;
        ready_next     = ready_reg;
        ovf_next       = ovf_reg;
        kt_next        = kt_reg;
        desc_next      = desc_reg;
        i_next         = i_reg;
        b_next         = b_reg;
        pass_next      = pass_reg;
        run_next       = run_reg;
        fsel_next      = fsel_reg;
        res_valid_next = cmd.rd_emit;

        if (cfg_we)
        begin
            if (cfg_index == CFG_KEY_TYPE)
            begin
                kt_next = cfg_data;
            end
            else if (cfg_index == CFG_DESCENDING)
            begin
                desc_next = cfg_data[0];
            end
        end

        if (cmd.load)
        begin
            if (ready_reg)
            begin
                rp_next    = '0;
                ready_next = 1'b0;
                ovf_next   = 1'b0;
            end
            if (store_ok)
            begin
                count_next = ready_reg ? CW'(1) : (count_reg + CW'(1));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.sort_init)
        begin
            i_next    = '0;
            b_next    = '0;
            pass_next = '0;
        end

        if (cmd.clear_step)
        begin
            b_next = sts.clr_end ? '0 : (b_reg + BW'(1));
        end

        if (cmd.pfx_step)
        begin
            b_next   = sts.pfx_end ? '0 : (b_reg + BW'(1));
            run_next = (b_reg == '0) ? '0 : (run_reg + cnt_rdata);
        end

        if (cmd.hist_upd || cmd.scat_upd)
        begin
            i_next = sts.item_last ? '0 : (i_reg + AW'(1));
        end

        if (cmd.pass_adv)
        begin
            pass_next = pass_reg + PW'(1);
        end

        if (cmd.sort_done)
        begin
            ready_next = 1'b1;
            rp_next    = '0;
            fsel_next  = pass_reg[0];
        end

        if (cmd.rd_emit && rd_ok)
        begin
            rp_next = rp_reg + CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rp_reg        <= '0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            kt_reg        <= KT_U32;
            desc_reg      <= 1'b0;
            i_reg         <= '0;
            b_reg         <= '0;
            pass_reg      <= '0;
            run_reg       <= '0;
            fsel_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            ready_reg     <= ready_next;
            ovf_reg       <= ovf_next;
            kt_reg        <= kt_next;
            desc_reg      <= desc_next;
            i_reg         <= i_next;
            b_reg         <= b_next;
            pass_reg      <= pass_next;
            run_reg       <= run_next;
            fsel_reg      <= fsel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Key and tag stores.
    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            key_mem[store_addr] <= key;
            tag_mem[store_addr] <= tag;
        end
        key_rdata <= key_mem[key_raddr];
        tag_rdata <= tag_mem[key_raddr];
    end

    // Order buffers: each pass scatters into the one it does not read.
    always_ff @(posedge clk)
    begin
        if (cmd.scat_upd && pass_reg[0])
        begin
            ping_mem[cnt_rdata[AW-1:0]] <= it_reg;
        end
        ping_rdata <= ping_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scat_upd && !pass_reg[0])
        begin
            pong_mem[cnt_rdata[AW-1:0]] <= it_reg;
        end
        pong_rdata <= pong_mem[ord_raddr];
    end

    // Digit count memory.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    // Per-item pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.item_key)
        begin
            it_reg <= key_raddr;
        end
        if (cmd.item_cnt)
        begin
            digit_reg <= digit;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_emit)
        begin
            out_key_reg    <= rd_ok ? key_rdata : '0;
            out_tag_reg    <= rd_ok ? tag_rdata : '0;
            out_final_reg  <= rd_ok && ((rp_reg + CW'(1)) == count_reg);
            out_status_reg <= !rd_ok;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign sorted_key = out_key_reg;
    assign sorted_tag = out_tag_reg;
    assign final_res  = out_final_reg;
    assign status     = out_status_reg;
    assign overflowed = out_ovf_reg;

endmodule

`default_nettype wire

[src/radix_sort_multi_type_core.sv]
// ----------------------------------------------------------------------------
// radix_sort_multi_type_core: tagged-key LSD radix sorter
// Loads keys with tags, sorts them by a stable counting sort on DIGIT_BITS-bit
// digits and returns the keys and tags one by one in sorted order.
// ----------------------------------------------------------------------------
// A load (func 0) without last leaves busy low. A read (func 1) keeps busy
// high through the states RD_ORD, RD_KEY and RD_OUT, and its result strobe
// res_valid is registered from RD_OUT; one read gives exactly one result, and
// the receiver must take it in that cycle. A load with last set starts the
// sort: busy then stays high through all passes, 2 passes for 32-bit types or
// 4 for 64-bit types at 16-bit digits. Each pass sweeps all of the buckets of
// the count memory once to clear them and once for the prefix sum, and the
// histogram and scatter walks take each key through the ORD, KEY, CNT and UPD
// states, a read-modify-write of the count memory. Configuration writes are
// always accepted.
`default_nettype none

module radix_sort_multi_type_core #(
    parameter int MAX_ITEMS  = 4096,
    parameter int DIGIT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [63:0] key,
    input  wire logic [30:0] tag,
    input  wire logic        last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    output logic             res_valid,
    output logic [63:0]      sorted_key,
    output logic [30:0]      sorted_tag,
    output logic             final_res,
    output logic             status,
    output logic             overflowed
);
    import rsmt_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    rsmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .last  (last),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Storage and arithmetic.
    rsmt_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .key        (key),
        .tag        (tag),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .final_res  (final_res),
        .status     (status),
        .overflowed (overflowed)
    );

    // A result only ever follows a read that kept the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(busy))
        else $error("result strobe without a read in progress");

    // A load transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_LOAD)) |=> !res_valid)
        else $error("result after a load");

    // An empty read returns zero payload and no final mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status) |-> (sorted_key == '0 && sorted_tag == '0 && !final_res))
        else $error("empty read with nonzero payload");

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the radix sort core
// Drives loads and reads with random gaps and tracks the sorted order in a
// behavioral sorter. Every result strobe is checked field by field against
// the oldest expected read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsmt_pkg::*;

    localparam int CAPACITY    = 4096;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [63:0] skey;
        logic [30:0] stag;
        logic        fin;
        logic        st;
        logic        ovf;
    } readout_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        func = FUNC_LOAD;
    logic [63:0] key = '0;
    logic [30:0] tag = '0;
    logic        last = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_TYPE;
    logic [2:0]  cfg_data = '0;
    logic        busy, cfg_ready, res_valid;
    logic [63:0] sorted_key;
    logic [30:0] sorted_tag;
    logic        final_res, status, overflowed;

    // Sorter state kept by the testbench.
    logic [63:0] key_mem [CAPACITY];
    logic [30:0] tag_mem [CAPACITY];
    int          sorted_idx [$];
    int          load_count = 0;
    int          read_pos = 0;
    bit          set_sorted = 0;
    bit          set_overflow = 0;
    logic [2:0]  cur_type = KT_U32;
    bit          cur_desc = 0;

    readout_t    pending_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          loads_sent = 0;
    int          reads_sent = 0;
    int          sorts_run = 0;
    longint      cycles = 0;

    radix_sort_multi_type_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .key(key), .tag(tag), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .res_valid(res_valid), .sorted_key(sorted_key), .sorted_tag(sorted_tag),
        .final_res(final_res), .status(status), .overflowed(overflowed)
    );

    always #4 clk = ~clk;

    // Order key under the current type, folded for descending mode.
    function automatic logic [63:0] rank_of(input logic [63:0] raw);
        logic [63:0] r;
        bit          narrow;
        narrow = (cur_type == KT_U32) || (cur_type == KT_S32) || (cur_type == KT_FLOAT);
        case (cur_type)
            KT_U32:    r = {32'd0, raw[31:0]};
            KT_S32:    r = {32'd0, ~raw[31], raw[30:0]};
            KT_FLOAT:  r = raw[31] ? {32'd0, ~raw[31:0]} : {32'd0, ~raw[31], raw[30:0]};
            KT_DOUBLE: r = raw[63] ? ~raw : {~raw[63], raw[62:0]};
            KT_S64:    r = {~raw[63], raw[62:0]};
            default:   r = raw;
        endcase
        if (cur_desc)
            r = narrow ? (r ^ 64'h0000_0000_FFFF_FFFF) : ~r;
        return r;
    endfunction

    // Stable sort: the load index breaks ties, so plain sorting is enough.
    task automatic sort_loaded();
        logic [76:0] packed_keys [$];
        packed_keys = {};
        for (int i = 0; i < load_count; i++)
            packed_keys.push_back({rank_of(key_mem[i]), 13'(i)});
        packed_keys.sort();
        sorted_idx = {};
        foreach (packed_keys[i])
            sorted_idx.push_back(int'(packed_keys[i][12:0]));
        sorts_run++;
    endtask

    // Apply one accepted command to the sorter; a read yields a result.
    task automatic sorter_apply(input logic f, input logic [63:0] k, input logic [30:0] t,
                                input logic l, output readout_t r, output bit has_res);
        has_res = 0;
        r = '0;
        if (f == FUNC_LOAD) begin
            if (set_sorted) begin
                load_count = 0;
                read_pos = 0;
                set_sorted = 0;
                set_overflow = 0;
            end
            if (load_count < CAPACITY) begin
                key_mem[load_count] = k;
                tag_mem[load_count] = t;
                load_count++;
            end else begin
                set_overflow = 1;
            end
            if (l) begin
                sort_loaded();
                read_pos = 0;
                set_sorted = 1;
            end
        end else begin
            has_res = 1;
            if (set_sorted && read_pos < load_count) begin
                r.skey = key_mem[sorted_idx[read_pos]];
                r.stag = tag_mem[sorted_idx[read_pos]];
                r.fin  = (read_pos + 1 == load_count);
                r.st   = 1'b0;
                read_pos++;
            end else begin
                r.st = 1'b1;
            end
            r.ovf = set_overflow;
        end
    endtask

    // Issue one command after a gap; start stays high when the gap is zero.
    task automatic issue(input logic f, input logic [63:0] k, input logic [30:0] t,
                         input logic l, input bit typed, input readout_t typed_res);
        int       gap;
        readout_t r;
        bit       has_res;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func  <= f;
        key   <= k;
        tag   <= t;
        last  <= l;
        do @(posedge clk); while (busy);
        sorter_apply(f, k, t, l, r, has_res);
        if (has_res)
            pending_results.push_back(typed ? typed_res : r);
        if (f == FUNC_LOAD)
            loads_sent++;
        else
            reads_sent++;
    endtask

    // Hold start low, then wait until the block has drained.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One register write, after which cfg_valid is dropped again.
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_KEY_TYPE)
            cur_type = val;
        else
            cur_desc = val[0];
    endtask

    // Keys that hit sign boundaries, ties and full-range bits.
    function automatic logic [63:0] pick_key();
        logic [63:0] pool [8];
        pool = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000,
                 64'h0000_0000_7FFF_FFFF, 64'h1234_0000_FFFF_0001, 64'h0000_0001_0000_0000};
        case ($urandom_range(0, 3))
            0:       return pool[$urandom_range(0, 7)];
            1:       return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom_range(0, 7))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Load a set of n keys, with stray reads mixed in, then read it out.
    task automatic run_set(input int n, input int extra_reads);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                issue(FUNC_READ, {$urandom, $urandom}, 31'($urandom), 1'($urandom), 0, '0);
            issue(FUNC_LOAD, pick_key(), 31'($urandom), i == n - 1, 0, '0);
        end
        for (int i = 0; i < ((n > CAPACITY) ? 30 : n) + extra_reads; i++)
            issue(FUNC_READ, {$urandom, $urandom}, 31'($urandom), 1'($urandom), 0, '0);
    endtask

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge clk) begin
        readout_t got, want;
        if (rst_n && res_valid) begin
            got = '{sorted_key, sorted_tag, final_res, status, overflowed};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with none expected: key %h tag %h", got.skey,
                             got.stag);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp key %h tag %h fin %0d st %0d ovf %0d, got key %h tag %h fin %0d st %0d ovf %0d",
                                 want.skey, want.stag, want.fin, want.st, want.ovf,
                                 got.skey, got.stag, got.fin, got.st, got.ovf);
                end
            end
        end
    end

    // Run time guard.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Directed rows: typed expectations where the order is obvious.
    typedef struct {
        logic        f;
        logic [63:0] k;
        logic [30:0] t;
        logic        l;
        bit          typed;
        readout_t    res;
    } row_t;

    row_t directed [$];

    initial begin
        logic [2:0] kt_seq [8];
        kt_seq = '{KT_U32, KT_S32, KT_DOUBLE, KT_FLOAT, KT_S64, KT_U64, 3'd6, 3'd7};

        directed = '{
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1, '{64'h0, 31'h0, 1'b0, 1'b1, 1'b0}},
            '{FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 0, '0},
            '{FUNC_LOAD, 64'h0, 31'h0, 1'b0, 0, '0},
            '{FUNC_LOAD, 64'h1_0000_0005, 31'd5, 1'b0, 0, '0},
            '{FUNC_LOAD, 64'hFFFF_FFFF_0000_0005, 31'd6, 1'b1, 0, '0},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1, '{64'h0, 31'h0, 1'b0, 1'b0, 1'b0}},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1, '{64'h1_0000_0005, 31'd5, 1'b0, 1'b0, 1'b0}},
            '{FUNC_READ, 64'h0, 31'h0, 1'b1, 1,
              '{64'hFFFF_FFFF_0000_0005, 31'd6, 1'b0, 1'b0, 1'b0}},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1,
              '{64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1, '{64'h0, 31'h0, 1'b0, 1'b1, 1'b0}},
            '{FUNC_LOAD, 64'h3, 31'd9, 1'b1, 0, '0},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1, '{64'h3, 31'd9, 1'b1, 1'b0, 1'b0}},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 1, '{64'h0, 31'h0, 1'b0, 1'b1, 1'b0}},
            '{FUNC_LOAD, 64'h8000_0000_8000_0000, 31'd1, 1'b0, 0, '0},
            '{FUNC_LOAD, 64'h7FFF_FFFF_7FFF_FFFF, 31'd2, 1'b1, 0, '0},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 0, '0},
            '{FUNC_READ, 64'h0, 31'h0, 1'b0, 0, '0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            issue(directed[i].f, directed[i].k, directed[i].t, directed[i].l,
                  directed[i].typed, directed[i].res);
        drain();

        // One set per key type code, alternating the direction.
        for (int s = 0; s < 8; s++) begin
            write_reg(CFG_KEY_TYPE, kt_seq[s]);
            write_reg(CFG_DESCENDING, 3'(s % 2 == 0));
            run_set($urandom_range(40, 100), $urandom_range(0, 2));
            drain();
        end
        repeat (20) @(posedge clk);

        $display("Ran %0d loads and %0d reads over %0d sorts, all key type codes, both directions.",
                 loads_sent, reads_sent, sorts_run);
        $display("Checked %0d results including empty and stray reads; %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
